FILE: src/hpg_pkg.sv
// ----------------------------------------------------------------------------
// hpg_pkg: shared types and constants of the Halton point generator
// Field widths, default sizes, prime bases, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hpg_pkg;

  localparam int DIMS_DEF          = 4;
  localparam int INDEX_BITS_DEF    = 20;
  localparam int INV_FRAC_BITS_DEF = 24;

  localparam int COORD_W   = 32;
  localparam int DIM_W     = 2;
  localparam int BASE_W    = 3;
  localparam int BOUND_CNT = 4;
  localparam int CFG_IDX_W = 3;

  localparam int PRIME_0 = 2;
  localparam int PRIME_1 = 3;
  localparam int PRIME_2 = 5;
  localparam int PRIME_3 = 7;

  localparam logic [BASE_W-1:0] PRIME_BASE [BOUND_CNT] = '{
    BASE_W'(PRIME_0), BASE_W'(PRIME_1), BASE_W'(PRIME_2), BASE_W'(PRIME_3)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIGIT_MUL,
    ST_DIGIT_FIX,
    ST_DIV,
    ST_SCALE,
    ST_EMIT
  } hpg_state_t;

  typedef struct packed {
    logic             accept;
    logic             load;
    logic             digit_mul;
    logic             digit_fix;
    logic             div_step;
    logic             scale_mul;
    logic             emit;
    logic [DIM_W-1:0] dim;
  } hpg_cmd_t;

  typedef struct packed {
    logic work_zero;
    logic out_free;
  } hpg_stat_t;

endpackage

FILE: src/hpg_if.sv
// ----------------------------------------------------------------------------
// hpg_if: valid/ready channels of the Halton point generator
// Index channel into the block and coordinate channel out of it.
// ----------------------------------------------------------------------------
interface hpg_in_if #(
  parameter int INDEX_BITS = hpg_pkg::INDEX_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface hpg_out_if;
  logic                                valid;
  logic                                ready;
  logic [hpg_pkg::DIM_W-1:0]           dimension;
  logic signed [hpg_pkg::COORD_W-1:0]  coordinate;
  logic                                last_coordinate;

  modport source (output valid, output dimension, output coordinate,
                  output last_coordinate, input ready);
  modport sink   (input valid, input dimension, input coordinate,
                  input last_coordinate, output ready);
endinterface

FILE: src/hpg_ctrl.sv
// ----------------------------------------------------------------------------
// hpg_ctrl: sequencer of the Halton point generator
// Walks each dimension through load, digit extraction, fraction division,
// scaling and emit, and issues one command bundle per cycle.
// ----------------------------------------------------------------------------
module hpg_ctrl #(
  parameter int DIMS              = hpg_pkg::DIMS_DEF,
  parameter int INVERSE_FRAC_BITS = hpg_pkg::INV_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hpg_pkg::hpg_stat_t stat,
  output hpg_pkg::hpg_cmd_t  cmd
);
  import hpg_pkg::*;

  localparam int CNT_W = $clog2(INVERSE_FRAC_BITS);

  hpg_state_t       state_r, state_nxt;
  logic [DIM_W-1:0] dim_r, dim_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dim_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dim_r   <= dim_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dim_nxt   = dim_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOAD;
          dim_nxt   = '0;
        end
      end
      ST_LOAD: state_nxt = ST_DIGIT_MUL;
      ST_DIGIT_MUL: begin
        if (stat.work_zero) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end else begin
          state_nxt = ST_DIGIT_FIX;
        end
      end
      ST_DIGIT_FIX: state_nxt = ST_DIGIT_MUL;
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(INVERSE_FRAC_BITS - 1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) begin
          if (dim_r == DIM_W'(DIMS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_LOAD;
            dim_nxt   = dim_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    cmd           = '0;
    cmd.dim       = dim_r;
    cmd.accept    = (state_r == ST_IDLE) && in_valid;
    cmd.load      = (state_r == ST_LOAD);
    cmd.digit_mul = (state_r == ST_DIGIT_MUL) && !stat.work_zero;
    cmd.digit_fix = (state_r == ST_DIGIT_FIX);
    cmd.div_step  = (state_r == ST_DIV);
    cmd.scale_mul = (state_r == ST_SCALE);
    cmd.emit      = (state_r == ST_EMIT) && stat.out_free;
  end

endmodule

FILE: src/hpg_dp.sv
// ----------------------------------------------------------------------------
// hpg_dp: datapath of the Halton point generator
// Bound registers, base-p digit extraction by reciprocal multiply,
// restoring division of the reversed digits, scaling, offset, saturation
// and the output register.
// ----------------------------------------------------------------------------
module hpg_dp #(
  parameter int INDEX_BITS        = hpg_pkg::INDEX_BITS_DEF,
  parameter int INVERSE_FRAC_BITS = hpg_pkg::INV_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hpg_pkg::hpg_cmd_t                  cmd,
  output hpg_pkg::hpg_stat_t                 stat,
  input  logic [INDEX_BITS-1:0]              in_sample_index,
  input  logic                               cfg_wr_en,
  input  logic [hpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hpg_pkg::COORD_W-1:0]        cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hpg_pkg::DIM_W-1:0]          out_dimension,
  output logic signed [hpg_pkg::COORD_W-1:0] out_coordinate,
  output logic                               out_last_coordinate,
  input  logic                               last_dim
);
  import hpg_pkg::*;

  localparam int IB       = INDEX_BITS;
  localparam int FB       = INVERSE_FRAC_BITS;
  localparam int DEN_W    = IB + BASE_W;
  localparam int PROD_W   = 2 * IB;
  localparam int SPROD_W  = COORD_W + FB;
  localparam int SUM_W    = COORD_W + 2;
  localparam logic [63:0] ONE_SHIFT = 64'(1) << IB;

  // floor(2^IB / p): quotient estimate is exact or one low
  localparam logic [IB-1:0] RECIP [BOUND_CNT] = '{
    IB'(ONE_SHIFT / PRIME_0), IB'(ONE_SHIFT / PRIME_1),
    IB'(ONE_SHIFT / PRIME_2), IB'(ONE_SHIFT / PRIME_3)
  };

  logic [COORD_W-1:0] lower_r [BOUND_CNT];
  logic [COORD_W-1:0] upper_r [BOUND_CNT];

  logic [IB-1:0]      idx_r;
  logic [IB-1:0]      work_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DEN_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [FB-1:0]      inv_r;
  logic [COORD_W-1:0] lo_r;
  logic [COORD_W-1:0] width_r;
  logic [SPROD_W-1:0] sprod_r;

  logic                        out_valid_r;
  logic [DIM_W-1:0]            out_dim_r;
  logic [COORD_W-1:0]          out_coord_r;
  logic                        out_last_r;

  // bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BOUND_CNT; i++) begin
        lower_r[i] <= '0;
        upper_r[i] <= COORD_W'(65536);
      end
    end else if (cfg_wr_en) begin
      if (cfg_index[0]) begin
        upper_r[cfg_index[CFG_IDX_W-1:1]] <= cfg_wdata;
      end else begin
        lower_r[cfg_index[CFG_IDX_W-1:1]] <= cfg_wdata;
      end
    end
  end

  // range of the current dimension
  logic [COORD_W-1:0] bnd_a, bnd_b;
  logic [COORD_W:0]   diff_ab, diff_ba;
  logic               a_lt_b;

  always_comb begin
    bnd_a   = lower_r[cmd.dim];
    bnd_b   = upper_r[cmd.dim];
    diff_ab = {bnd_a[COORD_W-1], bnd_a} - {bnd_b[COORD_W-1], bnd_b};
    diff_ba = {bnd_b[COORD_W-1], bnd_b} - {bnd_a[COORD_W-1], bnd_a};
    a_lt_b  = diff_ab[COORD_W];
  end

  // digit step: quotient estimate, remainder, one correction
  logic [BASE_W-1:0] p_sel;
  logic [IB-1:0]     q_est, q_fix;
  logic [DEN_W-1:0]  q_times_p, rem_raw, rem_fix;
  logic              rem_over;
  logic [DEN_W-1:0]  num_next, den_next;

  always_comb begin
    p_sel     = PRIME_BASE[cmd.dim];
    q_est     = prod_r[PROD_W-1 -: IB];
    q_times_p = DEN_W'(q_est) * DEN_W'(p_sel);
    rem_raw   = DEN_W'(work_r) - q_times_p;
    rem_over  = (rem_raw >= DEN_W'(p_sel));
    rem_fix   = rem_over ? (rem_raw - DEN_W'(p_sel)) : rem_raw;
    q_fix     = q_est + IB'(rem_over);
    num_next  = DEN_W'(num_r * DEN_W'(p_sel)) + DEN_W'(rem_fix[BASE_W-1:0]);
    den_next  = DEN_W'(den_r * DEN_W'(p_sel));
  end

  // restoring division, one fraction bit a step
  logic [DEN_W:0] rem_sh;
  logic           rem_ge;

  always_comb begin
    rem_sh = {num_r, 1'b0};
    rem_ge = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= in_sample_index;
    end
    if (cmd.load) begin
      work_r  <= idx_r;
      num_r   <= '0;
      den_r   <= DEN_W'(1);
      inv_r   <= '0;
      lo_r    <= a_lt_b ? bnd_a : bnd_b;
      width_r <= a_lt_b ? diff_ba[COORD_W-1:0] : diff_ab[COORD_W-1:0];
    end
    if (cmd.digit_mul) begin
      prod_r <= PROD_W'(work_r) * PROD_W'(RECIP[cmd.dim]);
    end
    if (cmd.digit_fix) begin
      work_r <= q_fix;
      num_r  <= num_next;
      den_r  <= den_next;
    end
    if (cmd.div_step) begin
      num_r <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      inv_r <= {inv_r[FB-2:0], rem_ge};
    end
    if (cmd.scale_mul) begin
      sprod_r <= SPROD_W'(width_r) * SPROD_W'(inv_r);
    end
  end

  // offset and saturate
  logic [SUM_W-1:0]   sum;
  logic [COORD_W-1:0] coord_sat;

  always_comb begin
    sum = {{2{lo_r[COORD_W-1]}}, lo_r} + {2'b00, sprod_r[FB +: COORD_W]};
    priority if (!sum[SUM_W-1] && (sum[SUM_W-2] || sum[SUM_W-3])) begin
      coord_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (sum[SUM_W-1] && !(sum[SUM_W-2] && sum[SUM_W-3])) begin
      coord_sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      coord_sat = sum[COORD_W-1:0];
    end
  end

  // output register: drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dim_r   <= cmd.dim;
      out_coord_r <= coord_sat;
      out_last_r  <= last_dim;
    end
  end

  assign stat.work_zero      = (work_r == '0);
  assign stat.out_free       = !out_valid_r || out_ready;
  assign out_valid           = out_valid_r;
  assign out_dimension       = out_dim_r;
  assign out_coordinate      = out_coord_r;
  assign out_last_coordinate = out_last_r;

endmodule

FILE: src/halton_point_generator_top.sv
// Each dimension runs load, digit extraction, fraction division, scaling and emit in
// turn; the index is broken down one base-p digit at a time, and the fraction
// divider yields one bit per cycle. A new index is taken only after the last
// coordinate of the point has been loaded into the output register.
// Reset: synchronous, clears the sequencer and output valid, bounds to [0, 1.0).
// ----------------------------------------------------------------------------
// halton_point_generator_top: Halton point generator
// Turns a sample index into one Q16.16 coordinate per dimension, bases
// 2, 3, 5, 7, scaled into each dimension's configured range.
// ----------------------------------------------------------------------------
module halton_point_generator_top #(
  parameter int DIMS              = hpg_pkg::DIMS_DEF,
  parameter int INDEX_BITS        = hpg_pkg::INDEX_BITS_DEF,
  parameter int INVERSE_FRAC_BITS = hpg_pkg::INV_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hpg_in_if.sink                        in_if,
  hpg_out_if.source                     out_if,
  input  logic                          cfg_wr_en,
  input  logic [hpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpg_pkg::COORD_W-1:0]   cfg_wdata
);
  import hpg_pkg::*;

  hpg_cmd_t  cmd;
  hpg_stat_t stat;
  logic      in_ready;

  hpg_ctrl #(
    .DIMS              (DIMS),
    .INVERSE_FRAC_BITS (INVERSE_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hpg_dp #(
    .INDEX_BITS        (INDEX_BITS),
    .INVERSE_FRAC_BITS (INVERSE_FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_sample_index     (in_if.sample_index),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_if.valid),
    .out_ready           (out_if.ready),
    .out_dimension       (out_if.dimension),
    .out_coordinate      (out_if.coordinate),
    .out_last_coordinate (out_if.last_coordinate),
    .last_dim            (cmd.dim == DIM_W'(DIMS - 1))
  );

  assign in_if.ready = in_ready;

endmodule

FILE: src/hpg_checker.sv
// ----------------------------------------------------------------------------
// hpg_checker: port-level checks of the Halton point generator
// Output hold under stall, last flag against dimension, one point at a
// time, and reset behavior of the output channel.
// ----------------------------------------------------------------------------
module hpg_checker #(
  parameter int DIMS = hpg_pkg::DIMS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [hpg_pkg::DIM_W-1:0]          out_dimension,
  input logic signed [hpg_pkg::COORD_W-1:0] out_coordinate,
  input logic                               out_last_coordinate
);
  import hpg_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coordinate)
      && $stable(out_dimension) && $stable(out_last_coordinate))
    else $error("output beat changed under stall");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_coordinate == (out_dimension == DIM_W'(DIMS - 1))))
    else $error("last flag does not match final dimension");

  // a new index is taken only once every coordinate but the last has left
  a_idle_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last_coordinate)
    else $error("index accepted while a point is still in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second index taken while the first is at work");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind halton_point_generator_top hpg_checker #(
  .DIMS (DIMS)
) u_hpg_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_if.valid),
  .in_ready            (in_if.ready),
  .out_valid           (out_if.valid),
  .out_ready           (out_if.ready),
  .out_dimension       (out_if.dimension),
  .out_coordinate      (out_if.coordinate),
  .out_last_coordinate (out_if.last_coordinate)
);

FILE: verif/tb_halton_point_generator_top.sv
// ----------------------------------------------------------------------------
// tb_halton_point_generator_top: self-checking bench for the Halton generator
// Sends sample indices through the input channel and predicts the Q16.16
// coordinate of every dimension from the programmed bounds. It then checks
// each coordinate beat in order, with random gaps on the sender and random
// stalls on the receiver, over several bound settings.
// ----------------------------------------------------------------------------
module tb_halton_point_generator_top;
  import hpg_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 12;
  localparam int N_DIMS           = DIMS_DEF;
  localparam int IDX_W            = INDEX_BITS_DEF;
  localparam int FRAC_W           = INV_FRAC_BITS_DEF;
  localparam int RANDOM_PHASES    = 4;
  localparam int POINTS_PER_PHASE = 25;
  localparam int TAIL_CYCLES      = 250;
  localparam int RUN_LIMIT        = 4000000;

  localparam logic signed [COORD_W-1:0] Q16_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q16_MIN   = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] Q16_ONE   = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] RESET_LOW = '0;
  localparam logic signed [COORD_W-1:0] RESET_UP  = Q16_ONE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_0, REG_UPPER_0, REG_LOWER_1, REG_UPPER_1,
    REG_LOWER_2, REG_UPPER_2, REG_LOWER_3, REG_UPPER_3
  } bound_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]          dimension;
    logic signed [COORD_W-1:0] coordinate;
    logic                      last_coordinate;
  } coord_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COORD_W-1:0]    cfg_wdata;

  hpg_in_if #(.INDEX_BITS(IDX_W)) in_ch ();
  hpg_out_if                      out_ch ();

  halton_point_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // bounds as the block holds them, and the next setting to program
  logic signed [COORD_W-1:0] bound_a [N_DIMS];
  logic signed [COORD_W-1:0] bound_b [N_DIMS];
  logic signed [COORD_W-1:0] plan_a  [N_DIMS];
  logic signed [COORD_W-1:0] plan_b  [N_DIMS];

  coord_beat_t pending_coords [$];

  int unsigned err_count;
  int unsigned points_sent;
  int unsigned coords_checked;
  int unsigned settings_applied;
  bit          in_gaps_on;
  bit          out_stalls_on;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // digits of idx mirrored around the radix point, truncated to FRAC_W bits
  function automatic longint unsigned radical_inverse_frac(logic [IDX_W-1:0] idx,
                                                           int unsigned base);
    longint unsigned mirrored;
    longint unsigned span;
    int unsigned     n;
    mirrored = 0;
    span     = 1;
    n        = idx;
    while (n != 0) begin
      mirrored = mirrored * base + n % base;
      span     = span * base;
      n        = n / base;
    end
    return (mirrored << FRAC_W) / span;
  endfunction

  function automatic logic signed [COORD_W-1:0] halton_coordinate(logic [IDX_W-1:0] idx,
                                                                 int d);
    longint          lo;
    longint          hi;
    longint          r;
    longint unsigned span;
    longint unsigned inv;
    longint unsigned scaled;
    lo = bound_a[d];
    hi = bound_b[d];
    if (lo > hi) begin
      r  = lo;
      lo = hi;
      hi = r;
    end
    span   = hi - lo;
    inv    = radical_inverse_frac(idx, PRIME_BASE[d]);
    scaled = (span * inv) >> FRAC_W;
    r      = lo + longint'(scaled);
    if (r > longint'(Q16_MAX)) r = Q16_MAX;
    if (r < longint'(Q16_MIN)) r = Q16_MIN;
    return r[COORD_W-1:0];
  endfunction

  function automatic bound_reg_t bound_reg(int d, bit upper);
    case (d)
      0:       return upper ? REG_UPPER_0 : REG_LOWER_0;
      1:       return upper ? REG_UPPER_1 : REG_LOWER_1;
      2:       return upper ? REG_UPPER_2 : REG_LOWER_2;
      default: return upper ? REG_UPPER_3 : REG_LOWER_3;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned     base;
    int unsigned     k;
    longint unsigned p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return IDX_W'($urandom);
      4:          return IDX_W'($urandom_range(0, 63));
      5: begin
        // land on a digit-count boundary of one of the bases
        base = PRIME_BASE[$urandom_range(0, N_DIMS - 1)];
        p    = 1;
        k    = $urandom_range(1, IDX_W);
        while (k != 0 && p * base < (longint'(1) << IDX_W)) begin
          p = p * base;
          k--;
        end
        return IDX_W'(p + $urandom_range(0, 2) - 1);
      end
      6:          return ~(IDX_W'(1) << $urandom_range(0, IDX_W - 1));
      7:          return IDX_W'(1) << $urandom_range(0, IDX_W - 1);
      8:          return '1;
      default:    return IDX_W'($urandom & $urandom);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_bound();
    int v;
    case ($urandom_range(0, 7))
      0: return Q16_MIN;
      1: return Q16_MAX;
      2: return '0;
      3, 4: begin
        // within +/-16.0
        v = int'($urandom_range(0, 2097152)) - 1048576;
        return v;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t beat %0d: %s", $time, coords_checked, msg);
    err_count++;
  endtask

  task automatic write_bound(input int d, input bit upper,
                             input logic signed [COORD_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= bound_reg(d, upper);
    cfg_wdata <= value;
    @(posedge clk);
    if (upper) bound_b[d] = value;
    else bound_a[d] = value;
  endtask

  // call only with the block idle: every coordinate back, input valid low
  task automatic apply_plan();
    for (int d = 0; d < N_DIMS; d++) begin
      write_bound(d, 1'b0, plan_a[d]);
      write_bound(d, 1'b1, plan_b[d]);
    end
    cfg_wr_en <= 1'b0;
    settings_applied++;
  endtask

  task automatic randomize_plan();
    for (int d = 0; d < N_DIMS; d++) begin
      plan_a[d] = pick_bound();
      plan_b[d] = ($urandom_range(0, 9) == 0) ? plan_a[d] : pick_bound();
    end
  endtask

  task automatic drain_points();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_coords.size() != 0);
  endtask

  // valid stays high across back-to-back beats; drop it only for a gap
  task automatic send_index(input logic [IDX_W-1:0] idx);
    int unsigned gap;
    coord_beat_t beat;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    for (int d = 0; d < N_DIMS; d++) begin
      beat.dimension       = DIM_W'(d);
      beat.coordinate      = halton_coordinate(idx, d);
      beat.last_coordinate = (d == N_DIMS - 1);
      pending_coords.insert(pending_coords.size(), beat);
    end
    points_sent++;
  endtask

  task automatic test_reset_bounds();
    logic [IDX_W-1:0] picks [12] = '{
      20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'h80000, 20'd531441, 20'd390625,
      20'd823543, 20'hFFFFF, 20'hAAAAA, 20'h55555
    };
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    foreach (picks[i]) send_index(picks[i]);
    drain_points();
  endtask

  task automatic test_extreme_bounds();
    logic [IDX_W-1:0] picks [6] = '{
      20'd0, 20'd1, 20'hFFFFF, 20'd531440, 20'd823543, 20'h80000
    };
    // full span, full span reversed, zero width, small span reversed
    plan_a[0] = Q16_MIN;        plan_b[0] = Q16_MAX;
    plan_a[1] = Q16_MAX;        plan_b[1] = Q16_MIN;
    plan_a[2] = -3 * Q16_ONE;   plan_b[2] = -3 * Q16_ONE;
    plan_a[3] = 5 * Q16_ONE;    plan_b[3] = -2 * Q16_ONE;
    apply_plan();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    foreach (picks[i]) send_index(picks[i]);
    drain_points();
  endtask

  task automatic test_random_points();
    int unsigned hold_at;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_points();
      randomize_plan();
      apply_plan();
      in_gaps_on    = (ph != 1);
      out_stalls_on = (ph != 2);
      hold_at       = $urandom_range(5, POINTS_PER_PHASE - 5);
      for (int i = 0; i < POINTS_PER_PHASE; i++) begin
        // hold the sender until the pipeline is empty once per phase
        if (i == hold_at) drain_points();
        send_index(pick_index());
      end
    end
    drain_points();
  endtask

  // receiver: random stalls; none start while out_stalls_on is clear
  initial begin
    int unsigned stall_left;
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // compare each coordinate beat with the oldest prediction
  initial begin
    coord_beat_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_coords.size() == 0) begin
          report_mismatch($sformatf("unexpected beat dim %0d coord %0d last %0b",
                                    out_ch.dimension, out_ch.coordinate,
                                    out_ch.last_coordinate));
        end else begin
          want = pending_coords.pop_front();
          if (out_ch.dimension !== want.dimension)
            report_mismatch($sformatf("dimension %0d, expected %0d",
                                      out_ch.dimension, want.dimension));
          if (out_ch.coordinate !== want.coordinate)
            report_mismatch($sformatf("dim %0d coordinate %0d, expected %0d",
                                      want.dimension, out_ch.coordinate,
                                      want.coordinate));
          if (out_ch.last_coordinate !== want.last_coordinate)
            report_mismatch($sformatf("dim %0d last_coordinate %0b, expected %0b",
                                      want.dimension, out_ch.last_coordinate,
                                      want.last_coordinate));
        end
        coords_checked++;
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d coordinate beats outstanding", pending_coords.size());
    $display("tb_halton_point_generator_top failed");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.sample_index <= '0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= REG_LOWER_0;
    cfg_wdata          <= '0;
    for (int d = 0; d < N_DIMS; d++) begin
      bound_a[d] = RESET_LOW;
      bound_b[d] = RESET_UP;
    end
    err_count        = 0;
    points_sent      = 0;
    coords_checked   = 0;
    settings_applied = 0;
    in_gaps_on       = 1'b1;
    out_stalls_on    = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_bounds();
    test_extreme_bounds();
    test_random_points();

    drain_points();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d points, %0d coordinate beats, over %0d programmed bound sets",
             points_sent, coords_checked, settings_applied + 1);
    $display("covered reset, reversed, zero-width and full-span bounds with gaps and stalls");
    if (err_count == 0) begin
      $display("tb_halton_point_generator_top passed");
    end else begin
      $display("tb_halton_point_generator_top failed");
    end
    $finish;
  end

endmodule
